>>> src/fqp_pkg.sv
// ----------------------------------------------------------------------------
// fqp_pkg: shared types and constants for the fastq record parser
// Input and result beat layouts, the command passed from front to back,
// character codes and counter widths.
// ----------------------------------------------------------------------------
package fqp_pkg;

    // counter widths and saturation limits
    localparam int BASE_COUNT_BITS   = 20;
    localparam int HEADER_COUNT_BITS = 16;
    localparam int RECORD_BITS       = 32;

    localparam logic [BASE_COUNT_BITS-1:0]   BASE_MAX   = '1;
    localparam logic [HEADER_COUNT_BITS-1:0] HEADER_MAX = '1;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BASE   = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        kind_t                        kind;
        logic [7:0]                   byte_value;
        logic [BASE_COUNT_BITS-1:0]   base_count;
        logic [HEADER_COUNT_BITS-1:0] header_count;
        logic [RECORD_BITS-1:0]       record_number;
    } result_t;

    // one command per result beat still to be built
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

>>> src/fqp_front.sv
// ----------------------------------------------------------------------------
// fqp_front: byte classifier
// Tracks the record phase and turns each input beat into at most one
// command for the back end.
// ----------------------------------------------------------------------------
module fqp_front
    import fqp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_HDR_LEAD,
        PH_HDR,
        PH_SEQ,
        PH_PLUS,
        PH_PLUS_CR,
        PH_QUAL
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   error_reg, error_next;
    logic [7:0] c;

    assign c = item.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        error_next = error_reg;
        cmd_valid  = 1'b0;
        cmd.kind   = KIND_END;
        cmd.value  = 8'd0;
        if (error_reg)
        begin
            // sticky error: everything is dropped
        end
        else if (item.stream_end)
        begin
            if (phase_reg != PH_SEEK)
            begin
                cmd_valid  = 1'b1;
                phase_next = PH_SEEK;
            end
        end
        else
        begin
            case (phase_reg)
                PH_SEEK:
                begin
                    if (is_space(c))
                    begin
                    end
                    else if (c == CH_AT)
                    begin
                        phase_next = PH_HDR_LEAD;
                    end
                    else
                    begin
                        error_next = 1'b1;
                        cmd_valid  = 1'b1;
                        cmd.kind   = KIND_ERROR;
                        cmd.value  = c;
                    end
                end
                PH_HDR_LEAD, PH_HDR:
                begin
                    if (is_eol(c))
                    begin
                        phase_next = PH_SEQ;
                    end
                    else if (!(phase_reg == PH_HDR_LEAD && is_space(c)))
                    begin
                        phase_next = PH_HDR;
                        cmd_valid  = 1'b1;
                        cmd.kind   = KIND_HEADER;
                        cmd.value  = c;
                    end
                end
                PH_SEQ:
                begin
                    if (is_space(c))
                    begin
                    end
                    else if (c == CH_PLUS)
                    begin
                        phase_next = PH_PLUS;
                    end
                    else
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = KIND_BASE;
                        cmd.value = c;
                    end
                end
                PH_PLUS:
                begin
                    if (c == CH_CR)
                    begin
                        phase_next = PH_PLUS_CR;
                    end
                    else if (c == CH_LF)
                    begin
                        phase_next = PH_QUAL;
                    end
                end
                PH_PLUS_CR:
                begin
                    // lf completes crlf, a second cr ends an empty quality line
                    if (c == CH_CR)
                    begin
                        cmd_valid  = 1'b1;
                        phase_next = PH_SEEK;
                    end
                    else
                    begin
                        phase_next = PH_QUAL;
                    end
                end
                PH_QUAL:
                begin
                    if (is_eol(c))
                    begin
                        cmd_valid  = 1'b1;
                        phase_next = PH_SEEK;
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            error_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            error_reg <= error_next;
        end
    end

endmodule

>>> src/fqp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fqp_cmd_fifo: command queue
// Small register queue that decouples the classifier from the result builder.
// ----------------------------------------------------------------------------
module fqp_cmd_fifo
    import fqp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t                    mem_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg;
    logic [CMD_CNT_BITS-1:0] count_reg;

    assign full     = (count_reg == CMD_CNT_BITS'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> src/fqp_back.sv
// ----------------------------------------------------------------------------
// fqp_back: result builder
// Keeps the per-record counters and turns commands into result beats held
// in an output register.
// ----------------------------------------------------------------------------
module fqp_back
    import fqp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic [BASE_COUNT_BITS-1:0]   base_reg, base_next;
    logic [HEADER_COUNT_BITS-1:0] header_reg, header_next;
    logic [RECORD_BITS-1:0]       record_reg, record_next;
    logic                         out_valid_reg;
    result_t                      out_reg, out_next;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign cmd_pop = cmd_valid && (!out_valid_reg || pop);

    always_comb
    begin
        base_next                = base_reg;
        header_next              = header_reg;
        record_next              = record_reg;
        out_next.kind            = cmd.kind;
        out_next.byte_value      = cmd.value;
        out_next.base_count      = '0;
        out_next.header_count    = '0;
        out_next.record_number   = record_reg;
        case (cmd.kind)
            KIND_HEADER:
            begin
                if (header_reg != HEADER_MAX)
                begin
                    header_next = header_reg + 1'b1;
                end
            end
            KIND_BASE:
            begin
                if (base_reg != BASE_MAX)
                begin
                    base_next = base_reg + 1'b1;
                end
            end
            KIND_END:
            begin
                out_next.byte_value   = 8'd0;
                out_next.base_count   = base_reg;
                out_next.header_count = header_reg;
                base_next             = '0;
                header_next           = '0;
                record_next           = record_reg + 1'b1;
            end
            default:
            begin
                // format error: no counter change
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            header_reg    <= '0;
            record_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                base_reg   <= base_next;
                header_reg <= header_next;
                record_reg <= record_next;
            end
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> src/fastq_record_parser.sv
// ----------------------------------------------------------------------------
// fastq_record_parser: streaming fastq record parser
// Takes fastq text one byte per beat and gives header bytes, sequence bases,
// record-end summaries and a sticky format error as result beats.
// ----------------------------------------------------------------------------
// One input beat is taken per clock while full is low; each beat yields at
// most one result beat, so the sustained rate is one byte per cycle with
// pop held high. The front classifier decides each byte in the cycle it is
// pushed and writes a command into a four-entry queue; the back end turns
// one command per cycle into a result held in an output register, while
// that register is free or being popped. A result passes through the command
// queue and the output register before it reaches the result port. full
// rises only when the command queue holds four pending beats, i.e. when pop
// has been low long enough. Records open with '@' after optional whitespace;
// anything else gives one error beat and then the block drops all input
// until reset. An end-of-stream beat inside a record closes it with a
// record-end beat. Base and header counts saturate, the record number wraps.
module fastq_record_parser
    import fqp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // input side
    input  logic    push,
    output logic    full,
    input  item_t   item,
    // result side
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic accept;
    logic front_valid;
    cmd_t front_cmd;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // a beat is taken whenever the queue has room
    assign accept = push && !full;

    fqp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    // only beats that produce a result take a queue slot
    fqp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && front_valid),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    fqp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> src/fqp_checker.sv
// ----------------------------------------------------------------------------
// fqp_checker: port-level checks for the fastq record parser
// Watches the top-level ports and flags result beats that break the rules.
// ----------------------------------------------------------------------------
module fqp_checker
    import fqp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // a waiting beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    // only record-end beats carry counts
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_END) |->
            (result.base_count == '0 && result.header_count == '0))
        else $error("counts on a non record-end beat");

    // record-end beats carry no byte
    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_END) |-> (result.byte_value == 8'd0))
        else $error("byte value on a record-end beat");

    // the error beat is the last one
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.kind == KIND_ERROR) |=> empty)
        else $error("result beat after a format error");

endmodule

bind fastq_record_parser fqp_checker u_fqp_checker (.*);

>>> tb/tb_fastq_record_parser.sv
// ----------------------------------------------------------------------------
// tb_fastq_record_parser: self-checking testbench for the fastq record parser
// Runs a short directed byte table, then a random byte stream that follows
// the record layout, then one short hand-checked record, and last a sticky
// format error. A predictor runs alongside the stimulus and queues the result
// beats it expects. Every popped beat is checked field by field against the
// oldest one in that queue.
// ----------------------------------------------------------------------------
module tb_fastq_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import fqp_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 8;
    localparam int RANDOM_ITEMS      = 850;
    // covers the command queue, the output register and the slowest pop pattern
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 100_000;

    // predictor's view of where the parser stands inside a record
    typedef enum logic [2:0] {
        ST_FIND_AT,
        ST_HDR_BLANKS,
        ST_HDR,
        ST_SEQ,
        ST_PLUS,
        ST_PLUS_CR,
        ST_QUAL
    } parse_state_t;

    // how the result side pops during one stretch of cycles
    typedef enum logic [1:0] {
        POP_STREAM,
        POP_RANDOM,
        POP_TRICKLE
    } pop_style_t;

    // one row of stimulus: the input beat and, where typed in, its result
    typedef struct packed {
        item_t   beat;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    // predictor state, at its reset values
    parse_state_t                 pstate    = ST_FIND_AT;
    logic [BASE_COUNT_BITS-1:0]   bases     = '0;
    logic [HEADER_COUNT_BITS-1:0] hdr_bytes = '0;
    logic [RECORD_BITS-1:0]       rec_idx   = '0;
    logic                         locked    = 1'b0;

    result_t    expected_beats [$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;
    int         window_left = 0;
    pop_style_t pop_mode    = POP_STREAM;

    fastq_record_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // tab, lf, vt, ff, cr and space
    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    // record-end beat carries the counts of the record just closed
    function automatic void close_record(output result_t r);
        r               = '0;
        r.kind          = KIND_END;
        r.base_count    = bases;
        r.header_count  = hdr_bytes;
        r.record_number = rec_idx;
        rec_idx         = rec_idx + 1'b1;
        bases           = '0;
        hdr_bytes       = '0;
        pstate          = ST_FIND_AT;
    endfunction

    // advances the predictor by one input beat; returns 1 when a result is due
    function automatic bit parse_fastq_byte(input item_t it, output result_t r);
        logic [7:0] c;
        c               = it.data_byte;
        r               = '0;
        r.record_number = rec_idx;
        // after a format error nothing more comes out until reset
        if (locked)
            return 1'b0;
        // end of stream closes an open record, and is dropped between records
        if (it.stream_end)
        begin
            if (pstate == ST_FIND_AT)
                return 1'b0;
            close_record(r);
            return 1'b1;
        end
        case (pstate)
            ST_FIND_AT:
            begin
                if (is_blank(c))
                    return 1'b0;
                if (c == CH_AT)
                begin
                    bases     = '0;
                    hdr_bytes = '0;
                    pstate    = ST_HDR_BLANKS;
                    return 1'b0;
                end
                locked       = 1'b1;
                r.kind       = KIND_ERROR;
                r.byte_value = c;
                return 1'b1;
            end
            ST_HDR_BLANKS, ST_HDR:
            begin
                // a line end right after the '@' gives an empty header
                if (is_line_end(c))
                begin
                    pstate = ST_SEQ;
                    return 1'b0;
                end
                if ((pstate == ST_HDR_BLANKS) && is_blank(c))
                    return 1'b0;
                pstate = ST_HDR;
                if (hdr_bytes != HEADER_MAX)
                    hdr_bytes = hdr_bytes + 1'b1;
                r.kind       = KIND_HEADER;
                r.byte_value = c;
                return 1'b1;
            end
            ST_SEQ:
            begin
                if (is_blank(c))
                    return 1'b0;
                if (c == CH_PLUS)
                begin
                    pstate = ST_PLUS;
                    return 1'b0;
                end
                if (bases != BASE_MAX)
                    bases = bases + 1'b1;
                r.kind       = KIND_BASE;
                r.byte_value = c;
                return 1'b1;
            end
            ST_PLUS:
            begin
                if (c == CH_CR)
                    pstate = ST_PLUS_CR;
                else if (c == CH_LF)
                    pstate = ST_QUAL;
                return 1'b0;
            end
            ST_PLUS_CR:
            begin
                // lf of a crlf is swallowed, a second cr is an empty quality line
                if (c == CH_LF)
                begin
                    pstate = ST_QUAL;
                    return 1'b0;
                end
                if (c == CH_CR)
                begin
                    close_record(r);
                    return 1'b1;
                end
                pstate = ST_QUAL;
                return 1'b0;
            end
            ST_QUAL:
            begin
                if (is_line_end(c))
                begin
                    close_record(r);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                pstate = ST_FIND_AT;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t beat_row(input logic eos, input logic [7:0] b);
        stim_row_t row;
        row                 = '0;
        row.beat.stream_end = eos;
        row.beat.data_byte  = b;
        return row;
    endfunction

    // row whose result is typed in rather than taken from the predictor
    function automatic stim_row_t checked_row(input logic eos, input logic [7:0] b,
                                              input kind_t k, input logic [7:0] v,
                                              input logic [BASE_COUNT_BITS-1:0] bc,
                                              input logic [HEADER_COUNT_BITS-1:0] hc,
                                              input logic [RECORD_BITS-1:0] rn);
        stim_row_t row;
        row                    = beat_row(eos, b);
        row.typed              = 1'b1;
        row.want.kind          = k;
        row.want.byte_value    = v;
        row.want.base_count    = bc;
        row.want.header_count  = hc;
        row.want.record_number = rn;
        return row;
    endfunction

    function automatic logic [7:0] rand_byte_avoiding(input bit no_eol, input bit no_blank,
                                                      input bit no_plus);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((no_eol && is_line_end(c)) || (no_blank && is_blank(c)) ||
               (no_plus && (c == CH_PLUS)));
        return c;
    endfunction

    function automatic logic [7:0] rand_eol();
        return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
    endfunction

    // whitespace byte, line ends only when asked for
    function automatic logic [7:0] rand_blank(input bit with_eol);
        case ($urandom_range(0, with_eol ? 5 : 3))
            0:       return CH_TAB;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CH_SPACE;
            4:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // mostly well-formed fastq text with random content, picked from where
    // the predictor stands; never a stray byte at record start, since that
    // error locks the block for the rest of the run
    function automatic item_t next_random_beat();
        item_t       it;
        int unsigned roll;
        it.stream_end = 1'b0;
        it.data_byte  = 8'($urandom_range(0, 255));
        // occasional end of stream, often in the middle of a record
        if ($urandom_range(0, 99) < 2)
        begin
            it.stream_end = 1'b1;
            return it;
        end
        roll = $urandom_range(0, 99);
        case (pstate)
            ST_FIND_AT:
                it.data_byte = (roll < 75) ? CH_AT : rand_blank(1'b1);
            ST_HDR_BLANKS:
                if (roll < 20)
                    it.data_byte = rand_blank(1'b0);
                else if (roll < 35)
                    it.data_byte = rand_eol();
                else
                    it.data_byte = rand_byte_avoiding(1'b1, 1'b0, 1'b0);
            ST_HDR:
                it.data_byte = (roll < 15) ? rand_eol() : rand_byte_avoiding(1'b1, 1'b0, 1'b0);
            ST_SEQ:
                if (roll < 12)
                    it.data_byte = CH_PLUS;
                else if (roll < 22)
                    it.data_byte = rand_blank(1'b1);
                else if (roll < 80)
                    case ($urandom_range(0, 4))
                        0:       it.data_byte = "A";
                        1:       it.data_byte = "C";
                        2:       it.data_byte = "G";
                        3:       it.data_byte = "T";
                        default: it.data_byte = "N";
                    endcase
                else
                    it.data_byte = rand_byte_avoiding(1'b0, 1'b1, 1'b1);
            ST_PLUS:
                it.data_byte = (roll < 40) ? rand_eol() : rand_byte_avoiding(1'b1, 1'b0, 1'b0);
            ST_PLUS_CR:
                if (roll < 50)
                    it.data_byte = CH_LF;
                else if (roll < 70)
                    it.data_byte = CH_CR;
                else
                    it.data_byte = rand_byte_avoiding(1'b1, 1'b0, 1'b0);
            ST_QUAL:
                it.data_byte = (roll < 20) ? rand_eol() : rand_byte_avoiding(1'b1, 1'b0, 1'b0);
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // input side: bursts of beats with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_beat(input stim_row_t row);
        result_t predicted;
        bit      produced;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // now and then a long burst, so some stretches run without gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        push <= 1'b1;
        item <= row.beat;
        // the beat is taken at the first edge that sees full low
        do
            @(posedge clk);
        while (full);
        burst_left = burst_left - 1;
        produced = parse_fastq_byte(row.beat, predicted);
        if (row.typed)
            expected_beats.push_back(row.want);
        else if (produced)
            expected_beats.push_back(predicted);
    endtask

    // ------------------------------------------------------------------
    // result side: compare each popped beat with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_beat(input result_t got);
        result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat: kind %0d byte_value %02h", got.kind,
                   got.byte_value);
            error_count++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                error_count++;
            end
            if (got.byte_value !== want.byte_value)
            begin
                $error("byte_value: expected %02h, got %02h", want.byte_value, got.byte_value);
                error_count++;
            end
            if (got.base_count !== want.base_count)
            begin
                $error("base_count: expected %0d, got %0d", want.base_count, got.base_count);
                error_count++;
            end
            if (got.header_count !== want.header_count)
            begin
                $error("header_count: expected %0d, got %0d", want.header_count,
                       got.header_count);
                error_count++;
            end
            if (got.record_number !== want.record_number)
            begin
                $error("record_number: expected %0d, got %0d", want.record_number,
                       got.record_number);
                error_count++;
            end
        end
    endtask

    // pop pattern: stretches of full-rate popping, random popping and a
    // trickle of pops that backs the block up until full
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (rst_n && pop && !empty)
            check_beat(result);
        if (window_left == 0)
        begin
            pop_mode    = pop_style_t'($urandom_range(0, 2));
            window_left = $urandom_range(30, 300);
        end
        window_left = window_left - 1;
        case (pop_mode)
            POP_STREAM: pop <= 1'b1;
            POP_RANDOM: pop <= ($urandom_range(0, 3) != 0);
            default:    pop <= ((cycle_count % 10) == 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
                     expected_beats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t directed_rows [25];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed records: extremes, header, base and record-end kinds and the line-end corner cases
        directed_rows = '{
            // end of stream between records gives nothing
            beat_row(1'b1, 8'hFF),
            beat_row(1'b0, CH_SPACE),
            beat_row(1'b0, CH_AT),
            // blank before the header is skipped
            beat_row(1'b0, CH_TAB),
            checked_row(1'b0, 8'hFF, KIND_HEADER, 8'hFF, 0, 0, 0),
            beat_row(1'b0, "h"),
            beat_row(1'b0, CH_CR),
            // lf of the header's crlf is whitespace inside the sequence
            beat_row(1'b0, CH_LF),
            checked_row(1'b0, 8'h00, KIND_BASE, 8'h00, 0, 0, 0),
            beat_row(1'b0, "A"),
            beat_row(1'b0, CH_PLUS),
            // crlf after the plus line
            beat_row(1'b0, CH_CR),
            beat_row(1'b0, CH_LF),
            beat_row(1'b0, "I"),
            checked_row(1'b0, CH_CR, KIND_END, 8'h00, 2, 2, 0),
            // lf left over after the quality cr
            beat_row(1'b0, CH_LF),
            beat_row(1'b0, CH_AT),
            // empty header, then no bases at all
            beat_row(1'b0, CH_LF),
            beat_row(1'b0, CH_PLUS),
            // byte after the plus cr opens the quality line
            beat_row(1'b0, CH_CR),
            beat_row(1'b0, "F"),
            checked_row(1'b0, CH_LF, KIND_END, 8'h00, 0, 0, 1),
            beat_row(1'b0, CH_AT),
            beat_row(1'b0, "Z"),
            // end of stream inside a record closes it
            checked_row(1'b1, 8'h00, KIND_END, 8'h00, 0, 1, 2)
        };
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // random records, checked against the predictor
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            item_t it;
            it = next_random_beat();
            send_beat(beat_row(it.stream_end, it.data_byte));
        end

        // close whatever is open, then one short record with a typed result
        if (pstate != ST_FIND_AT)
            send_beat(beat_row(1'b1, 8'h00));
        send_beat(beat_row(1'b0, CH_AT));
        send_beat(beat_row(1'b0, "r"));
        send_beat(beat_row(1'b0, CH_LF));
        send_beat(beat_row(1'b0, "A"));
        send_beat(beat_row(1'b0, CH_PLUS));
        send_beat(beat_row(1'b0, CH_LF));
        send_beat(checked_row(1'b0, CH_CR, KIND_END, 8'h00, 1, 1, rec_idx));

        // stray byte at record start: one error beat, then everything is dropped
        send_beat(checked_row(1'b0, "X", KIND_ERROR, "X", 0, 0, rec_idx));
        send_beat(beat_row(1'b0, CH_AT));
        send_beat(beat_row(1'b0, "A"));
        send_beat(beat_row(1'b1, 8'hFF));
        send_beat(beat_row(1'b0, CH_LF));
        push <= 1'b0;

        // wait for the last expected beat, then watch for strays
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
